// ===== rtl/grom_pkg.sv =====
`timescale 1ns / 1ps

package grom_pkg;

    // Widths of the request and result fields.
    localparam int unsigned FUNC_W   = 1;
    localparam int unsigned TAG_W    = 2;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned SIZE_W   = 7;
    localparam int unsigned DIM_W    = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 13;

    // Stream data widths, padded to whole bytes.
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 16;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes (byte address bit 2).
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Request operations.
    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Saturation limit of the overlap count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Reset value of both grid size registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_OOB     = 2'd1,
        ST_OVERLAP = 2'd2
    } status_t;

endpackage

// ===== rtl/grid_rectangle_occupancy_map_top.sv =====
// Throughput: one request at a time; the single-port cell memory visits one cell per cycle,
// so a new request is not taken until the result of the last one has been loaded for output.
// Reset: control state clears at once, then a clearing pass writes zero to every cell of the
// cell memory before the first request is accepted.
`timescale 1ns / 1ps

module grid_rectangle_occupancy_map_top #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] func, [2:1] tag, [8:3] pos_x, [14:9] pos_y, [21:15] rect_width,
    // [28:22] rect_height, [31:29] zero
    input  logic [grom_pkg::IN_DATA_W-1:0]      s_tdata,

    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [14:2] overlap_count, [15] zero
    output logic [grom_pkg::OUT_DATA_W-1:0]     m_tdata,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [grom_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [grom_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [grom_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam int unsigned DW = grom_pkg::DIM_W;
    localparam int unsigned TW = grom_pkg::TAG_W;
    localparam int unsigned CW = grom_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_WRITE,
        S_RESULT
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          clr_addr_reg;

    logic [DW-1:0]          grid_rows_reg;
    logic [DW-1:0]          grid_cols_reg;

    logic [DW-1:0]          x0_reg;
    logic [DW-1:0]          y0_reg;
    logic [DW-1:0]          xe_reg;
    logic [DW-1:0]          ye_reg;
    logic [DW-1:0]          c_reg;
    logic [DW-1:0]          r_reg;
    logic [TW-1:0]          wtag_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    grom_pkg::status_t      res_status_reg;
    logic                   rd_pend_reg;

    logic                   m_tvalid_reg;
    grom_pkg::status_t      m_status_reg;
    logic [CW-1:0]          m_count_reg;

    // Cell memory and its port.
    logic [TW-1:0]          cell_mem [DEPTH];
    logic [TW-1:0]          rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_addr;
    logic [TW-1:0]          mem_wdata;

    // Unpacked request fields.
    logic                   in_func;
    logic [TW-1:0]          in_tag;
    logic [grom_pkg::POS_W-1:0]  in_x;
    logic [grom_pkg::POS_W-1:0]  in_y;
    logic [grom_pkg::SIZE_W-1:0] in_w;
    logic [grom_pkg::SIZE_W-1:0] in_h;

    logic [DW-1:0]          rows_use;
    logic [DW-1:0]          cols_use;
    logic [DW:0]            x_sum;
    logic [DW:0]            y_sum;
    logic                   in_oob;
    logic                   in_empty;

    logic [AW-1:0]          cell_addr;
    logic                   col_last;
    logic                   row_last;
    logic                   cfg_wr;
    logic                   s_accept;
    logic                   out_free;

    assign in_func = s_tdata[0];
    assign in_tag  = s_tdata[2:1];
    assign in_x    = s_tdata[8:3];
    assign in_y    = s_tdata[14:9];
    assign in_w    = s_tdata[21:15];
    assign in_h    = s_tdata[28:22];

    // Grid size in use, saturated to the memory dimensions.
    assign rows_use = (32'(grid_rows_reg) > MAX_ROWS) ? DW'(MAX_ROWS) : grid_rows_reg;
    assign cols_use = (32'(grid_cols_reg) > MAX_COLS) ? DW'(MAX_COLS) : grid_cols_reg;

    // Bounds test on sums one bit wider than the wider operand.
    assign x_sum    = {2'b00, in_x} + {1'b0, in_w};
    assign y_sum    = {2'b00, in_y} + {1'b0, in_h};
    assign in_oob   = (x_sum > {1'b0, cols_use}) || (y_sum > {1'b0, rows_use});
    assign in_empty = (in_w == '0) || (in_h == '0);

    // Position within the rectangle walk.
    assign cell_addr = AW'(32'(r_reg) * MAX_COLS + 32'(c_reg));
    assign col_last  = (c_reg == xe_reg - DW'(1));
    assign row_last  = (r_reg == ye_reg - DW'(1));

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Overlap count: cleared when a request is taken, then fed by the read
    // issued in the previous cycle.
    always_comb
    begin
        count_next = count_reg;
        if (s_accept)
        begin
            count_next = '0;
        end
        else if (rd_pend_reg && (rd_data_reg != '0) && (count_reg != grom_pkg::COUNT_MAX))
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = cell_addr;
        mem_wdata = wtag_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = '0;
            end
            S_SCAN:
            begin
                mem_re = 1'b1;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Single-port cell memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_addr];
        end
    end

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= grom_pkg::DIM_RESET;
            grid_cols_reg <= grom_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == grom_pkg::REG_GRID_ROWS)
            begin
                grid_rows_reg <= pwdata[DW-1:0];
            end
            else
            begin
                grid_cols_reg <= pwdata[DW-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == grom_pkg::REG_GRID_ROWS)
        begin
            prdata[DW-1:0] = grid_rows_reg;
        end
        else
        begin
            prdata[DW-1:0] = grid_cols_reg;
        end
    end

    // Request sequencer: clearing pass, scan, write and result hand-off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            x0_reg         <= '0;
            y0_reg         <= '0;
            xe_reg         <= '0;
            ye_reg         <= '0;
            c_reg          <= '0;
            r_reg          <= '0;
            wtag_reg       <= '0;
            count_reg      <= '0;
            res_status_reg <= grom_pkg::ST_DONE;
            m_status_reg   <= grom_pkg::ST_DONE;
            m_count_reg    <= '0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_SCAN);
            count_reg   <= count_next;
            // In the result state the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != S_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        x0_reg    <= DW'(in_x);
                        y0_reg    <= DW'(in_y);
                        c_reg     <= DW'(in_x);
                        r_reg     <= DW'(in_y);
                        xe_reg    <= x_sum[DW-1:0];
                        ye_reg    <= y_sum[DW-1:0];
                        wtag_reg  <= (in_func == grom_pkg::FUNC_CLEAR) ? '0 : in_tag;
                        if (in_oob)
                        begin
                            res_status_reg <= grom_pkg::ST_OOB;
                            state_reg      <= S_RESULT;
                        end
                        else if (in_empty)
                        begin
                            res_status_reg <= grom_pkg::ST_DONE;
                            state_reg      <= S_RESULT;
                        end
                        else if (in_func == grom_pkg::FUNC_CLEAR)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    if (col_last)
                    begin
                        c_reg <= x0_reg;
                        r_reg <= r_reg + DW'(1);
                        if (row_last)
                        begin
                            state_reg <= S_SCAN_END;
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + DW'(1);
                    end
                end

                S_SCAN_END:
                begin
                    // The last read lands in this cycle, so decide on the updated count.
                    if (count_next != '0)
                    begin
                        res_status_reg <= grom_pkg::ST_OVERLAP;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        c_reg     <= x0_reg;
                        r_reg     <= y0_reg;
                        state_reg <= S_WRITE;
                    end
                end

                S_WRITE:
                begin
                    if (col_last)
                    begin
                        c_reg <= x0_reg;
                        r_reg <= r_reg + DW'(1);
                        if (row_last)
                        begin
                            res_status_reg <= grom_pkg::ST_DONE;
                            state_reg      <= S_RESULT;
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + DW'(1);
                    end
                end

                S_RESULT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_count_reg  <= (res_status_reg == grom_pkg::ST_OVERLAP) ?
                                        count_reg : '0;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_status_reg};

endmodule
